@@ design/lsset_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsset_pkg: shared definitions for the liberty sparse set
// Mode codes, default sizes and the controller/datapath command and status
// bundles.
// ----------------------------------------------------------------------------
package lsset_pkg;

  localparam int DEF_BOARD_POINTS  = 512;
  localparam int DEF_MAX_LIBERTIES = 256;
  localparam int DEF_MAX_STONES    = 512;

  // Fixed transaction field widths.
  localparam int MODE_W  = 3;
  localparam int POINT_W = 9;
  localparam int LCNT_W  = 9;
  localparam int SCNT_W  = 10;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_START         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_STONE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_LIBERTY   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE_LIBERTY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR         = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;    // write zero into the position map at the sweep address
    logic capture;  // register the incoming transaction, read the position map
    logic list_rd;  // read the liberty list at the mapped slot and the last slot
    logic commit;   // apply the operation and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;  // sweep address is at the last map entry
    logic out_free;    // result register can take a new result this cycle
  } status_t;

endpackage

@@ design/lsset_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsset_ctrl: sequencing state machine
// Runs the position map sweep after reset, then steps each transaction
// through map read, list read and commit.
// ----------------------------------------------------------------------------
module lsset_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output lsset_pkg::cmd_t   cmd,
  input  lsset_pkg::status_t status
);
  import lsset_pkg::*;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      unique case (state)
        ST_INIT: begin
          if (status.sweep_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.sweep   = (state == ST_INIT);
    cmd.capture = (state == ST_IDLE) && s_tvalid;
    cmd.list_rd = (state == ST_LOOK);
    cmd.commit  = (state == ST_CHECK) && status.out_free;
  end

endmodule

@@ design/lsset_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsset_datapath: liberty list, position map, stone list and counters
// Holds the group state, performs membership checks and swap-with-last
// removal, and drives the result register.
// ----------------------------------------------------------------------------
module lsset_datapath #(
  parameter int BOARD_POINTS  = lsset_pkg::DEF_BOARD_POINTS,
  parameter int MAX_LIBERTIES = lsset_pkg::DEF_MAX_LIBERTIES,
  parameter int MAX_STONES    = lsset_pkg::DEF_MAX_STONES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lsset_pkg::cmd_t                 cmd,
  output lsset_pkg::status_t              status,
  input  logic [lsset_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lsset_pkg::M_DATA_W-1:0]  m_tdata
);
  import lsset_pkg::*;

  localparam int AW  = $clog2(BOARD_POINTS);           // map address
  localparam int PW  = ((AW > POINT_W) ? AW : POINT_W) + 1;
  localparam int SW  = $clog2(MAX_LIBERTIES);          // liberty slot
  localparam int LW  = $clog2(MAX_LIBERTIES + 1);      // liberty total
  localparam int SI  = $clog2(MAX_STONES);             // stone slot
  localparam int STW = $clog2(MAX_STONES + 1);         // stone total

  // Storage.
  logic [SW-1:0]      pos_map    [BOARD_POINTS];
  logic [AW-1:0]      lib_list   [MAX_LIBERTIES];
  logic [POINT_W-1:0] stone_list [MAX_STONES];

  // Group state.
  logic [LW-1:0]  lib_total;
  logic [STW-1:0] stone_total;
  logic           color;
  logic [AW-1:0]  sweep_addr;

  // Captured transaction and read data.
  logic [MODE_W-1:0]  mode_q;
  logic [POINT_W-1:0] point_q;
  logic [AW-1:0]      addr_q;
  logic               in_range_q;
  logic               color_q;
  logic [SW-1:0]      map_q;
  logic [AW-1:0]      list_a_q;
  logic [AW-1:0]      list_b_q;

  // Incoming fields.
  logic [MODE_W-1:0]  in_mode;
  logic [POINT_W-1:0] in_point;
  logic               in_color;
  logic [PW-1:0]      in_wide;
  logic [AW-1:0]      in_addr;

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_point = s_tdata[MODE_W +: POINT_W];
  assign in_color = s_tdata[MODE_W + POINT_W];
  assign in_wide  = PW'(in_point);
  assign in_addr  = in_wide[AW-1:0];

  // Commit decode.
  logic [LW-1:0]      last_full;
  logic               hit;
  logic               slot_lt_last;
  logic               lib_full;
  logic               stone_full;
  logic [LW-1:0]      lib_next;
  logic [STW-1:0]     stone_next;
  logic               color_next;
  logic               changed;
  logic               list_we;
  logic [SW-1:0]      list_wa;
  logic [AW-1:0]      list_wd;
  logic               map_we;
  logic [AW-1:0]      map_wa;
  logic [SW-1:0]      map_wd;
  logic               stone_we;
  logic [SI-1:0]      stone_wa;

  assign last_full    = lib_total - LW'(1);
  // A point is a member when its map slot is live and the list points back.
  assign hit          = in_range_q && (LW'(map_q) < lib_total) && (list_a_q == addr_q);
  assign slot_lt_last = LW'(map_q) < last_full;
  assign lib_full     = (lib_total == LW'(MAX_LIBERTIES));
  assign stone_full   = (stone_total == STW'(MAX_STONES));

  always_comb begin
    lib_next   = lib_total;
    stone_next = stone_total;
    color_next = color;
    changed    = 1'b0;
    list_we    = 1'b0;
    list_wa    = lib_total[SW-1:0];
    list_wd    = addr_q;
    map_we     = 1'b0;
    map_wa     = addr_q;
    map_wd     = lib_total[SW-1:0];
    stone_we   = 1'b0;
    stone_wa   = stone_total[SI-1:0];
    unique case (mode_q)
      MODE_START: begin
        lib_next   = '0;
        stone_next = STW'(1);
        color_next = color_q;
        stone_we   = 1'b1;
        stone_wa   = '0;
        changed    = 1'b1;
      end
      MODE_ADD_STONE: begin
        if (!stone_full) begin
          stone_we   = 1'b1;
          stone_next = stone_total + STW'(1);
          changed    = 1'b1;
        end
      end
      MODE_ADD_LIBERTY: begin
        if (in_range_q && !hit && !lib_full) begin
          list_we  = 1'b1;
          map_we   = 1'b1;
          lib_next = lib_total + LW'(1);
          changed  = 1'b1;
        end
      end
      MODE_ERASE_LIBERTY: begin
        if (hit) begin
          lib_next = last_full;
          changed  = 1'b1;
          // Move the last entry into the hole and repoint its map entry.
          if (slot_lt_last) begin
            list_we = 1'b1;
            list_wa = map_q;
            list_wd = list_b_q;
            map_we  = 1'b1;
            map_wa  = list_b_q;
            map_wd  = map_q;
          end
        end
      end
      MODE_CLEAR: begin
        lib_next   = '0;
        stone_next = '0;
        changed    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Position map: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      pos_map[sweep_addr] <= '0;
    end else if (cmd.commit && map_we) begin
      pos_map[map_wa] <= map_wd;
    end
    if (cmd.capture) begin
      map_q <= pos_map[in_addr];
    end
  end

  // Liberty list: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.commit && list_we) begin
      lib_list[list_wa] <= list_wd;
    end
    if (cmd.list_rd) begin
      list_a_q <= lib_list[map_q];
      list_b_q <= lib_list[last_full[SW-1:0]];
    end
  end

  // Stone list.
  always_ff @(posedge clk) begin
    if (cmd.commit && stone_we) begin
      stone_list[stone_wa] <= point_q;
    end
  end

  // Captured transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q     <= in_mode;
      point_q    <= in_point;
      addr_q     <= in_addr;
      in_range_q <= (in_wide < PW'(BOARD_POINTS));
      color_q    <= in_color;
    end
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lib_total   <= '0;
      stone_total <= '0;
      color       <= 1'b0;
      sweep_addr  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (cmd.commit) begin
        lib_total   <= lib_next;
        stone_total <= stone_next;
        color       <= color_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {4'b0000, changed, SCNT_W'(stone_next), LCNT_W'(lib_next)};
    end
  end

  assign status.sweep_done = (sweep_addr == AW'(BOARD_POINTS - 1));
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

@@ design/liberty_sparse_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liberty_sparse_set: one stone group as a sparse set of liberties
// Dense liberty list plus per-point position map for constant-time
// membership, insertion and swap-with-last removal, with a stone list,
// stone and liberty counts and a group color.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents
// -------   ---------  -----  ---------------------------------------------
// s_*       in         16     mode[2:0], point[11:3], stone_color[12]
// m_*       out        24     liberty_count[8:0], stone_count[18:9],
//                             changed[19]
//
// Each transaction steps through a map read, a list read and a commit. The
// acceptance edge reads the position map, the LOOK state reads the liberty
// list (mapped slot and last slot in parallel), and the CHECK state commits
// the list and map writes and loads the result register when that register
// can take a result. The next transaction can be accepted in the cycle after
// the commit, not before it. The single map port and the dependency of the
// list read on the map read set this sequence. After reset the block sweeps
// the position map to zero with s_tready low. A result waits in the output
// register while the next transaction is accepted and looked up; the commit
// stalls only while that register is still full and m_tready is low.
//
module liberty_sparse_set #(
  parameter int BOARD_POINTS  = lsset_pkg::DEF_BOARD_POINTS,
  parameter int MAX_LIBERTIES = lsset_pkg::DEF_MAX_LIBERTIES,
  parameter int MAX_STONES    = lsset_pkg::DEF_MAX_STONES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mode[2:0], point[11:3], stone_color[12], zero[15:13]
  input  logic [lsset_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // liberty_count[8:0], stone_count[18:9], changed[19], zero[23:20]
  output logic [lsset_pkg::M_DATA_W-1:0]  m_tdata
);
  import lsset_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all group state lives in the datapath.
  lsset_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Membership is decided by a live slot whose list entry points back to
  // the point, so start and clear reset the liberty total without clearing the map or list.
  lsset_datapath #(
    .BOARD_POINTS  (BOARD_POINTS),
    .MAX_LIBERTIES (MAX_LIBERTIES),
    .MAX_STONES    (MAX_STONES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
